/* hdl/md5_pkg.sv */
package md5_pkg;

    typedef logic [31:0] t_word;
    typedef logic [3:0][31:0] t_chain;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       is_last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        AFT_NONE,
        AFT_PAD,
        AFT_LEN,
        AFT_DONE
    } t_after;

    localparam t_chain CHAIN_INIT = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

    localparam logic [4:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam t_word SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] lo;
        logic [3:0] idx;
        lo = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = lo;
            2'd1:    idx = lo * 4'd5 + 4'd1;
            2'd2:    idx = lo * 4'd3 + 4'd5;
            default: idx = lo * 4'd7;
        endcase
        return idx;
    endfunction

    function automatic t_word round_f(input logic [1:0] phase, input t_word b,
                                      input t_word c, input t_word d);
        t_word f;
        case (phase)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic t_word rotl32(input t_word x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

    function automatic t_word swap32(input t_word x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

/* hdl/md5_front.sv */
module md5_front
    import md5_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_msg_byte,
    input  logic       i_has_byte,
    input  logic       i_is_last,
    output logic       o_item_valid,
    output t_item      o_item,
    input  logic       i_pop
);

    t_item                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wp;
    logic [QUEUE_AW-1:0]  r_rp;
    logic [QUEUE_AW:0]    r_cnt;
    logic [QUEUE_AW:0]    n_cnt;
    logic                 push;

    // Words that carry neither a byte nor an end mark are taken and dropped.
    assign o_ready      = (r_cnt != QUEUE_FULL);
    assign push         = i_valid && o_ready && (i_has_byte || i_is_last);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{msg_byte: i_msg_byte, has_byte: i_has_byte, is_last: i_is_last};
        end
    end

endmodule

/* hdl/md5_round.sv */
module md5_round
    import md5_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_chain     i_chain,
    output logic [3:0] o_widx,
    input  t_word      i_wdata,
    output logic       o_done,
    output t_chain     o_sum
);

    logic       r_load;
    logic       r_run;
    logic       r_fin;
    logic [5:0] r_cnt;
    t_word      r_a;
    t_word      r_b;
    t_word      r_c;
    t_word      r_d;
    t_word      r_pre;
    logic [5:0] pre_idx;
    t_word      f;
    t_word      t;
    t_word      nb;

    // The message word and constant of the following round are summed and registered during the current round.
    assign pre_idx = r_run ? r_cnt + 6'd1 : '0;
    assign o_widx  = msg_index(pre_idx);

    always_comb begin
        f  = round_f(r_cnt[5:4], r_b, r_c, r_d);
        t  = r_a + f + r_pre;
        nb = r_b + rotl32(t, ROT_AMT[{r_cnt[5:4], r_cnt[1:0]}]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load <= 1'b0;
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_load <= i_start;
            r_run  <= r_load || (r_run && (r_cnt != LAST_RND));
            r_fin  <= r_run && (r_cnt == LAST_RND);
            if (r_load) begin
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_load) begin
            r_a <= i_chain[0];
            r_b <= i_chain[1];
            r_c <= i_chain[2];
            r_d <= i_chain[3];
        end else if (r_run) begin
            r_a <= r_d;
            r_d <= r_c;
            r_c <= r_b;
            r_b <= nb;
        end
        if (r_load || r_run) begin
            r_pre <= i_wdata + SINE_K[pre_idx];
        end
    end

    assign o_done   = r_fin;
    assign o_sum[0] = i_chain[0] + r_a;
    assign o_sum[1] = i_chain[1] + r_b;
    assign o_sum[2] = i_chain[2] + r_c;
    assign o_sum[3] = i_chain[3] + r_d;

endmodule

/* hdl/md5_back.sv */
module md5_back
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_item_valid,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_first_half,
    output logic [63:0] o_digest_second_half,
    output logic        o_start,
    output t_chain      o_chain,
    input  logic [3:0]  i_widx,
    output t_word       o_wdata,
    input  logic        i_done,
    input  t_chain      i_sum
);

    t_state      r_state;
    t_state      n_state;
    t_after      r_after;
    t_after      n_after;
    logic [5:0]  r_pos;
    logic [5:0]  n_pos;
    logic [63:0] r_len;
    logic [63:0] n_len;
    t_chain      r_chain;
    t_chain      n_chain;
    t_word       r_blk [16];
    t_word       n_blk [16];
    logic        r_ov;
    logic        n_ov;
    logic [63:0] r_d1;
    logic [63:0] n_d1;
    logic [63:0] r_d2;
    logic [63:0] n_d2;

    always_comb begin
        n_state = r_state;
        n_after = r_after;
        n_pos   = r_pos;
        n_len   = r_len;
        n_chain = r_chain;
        n_blk   = r_blk;
        n_ov    = r_ov && !i_ready;
        n_d1    = r_d1;
        n_d2    = r_d2;
        o_pop   = 1'b0;
        o_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_item_valid) begin
                    o_pop = 1'b1;
                    if (i_item.has_byte) begin
                        n_blk[r_pos[5:2]][{r_pos[1:0], 3'b000} +: 8] = i_item.msg_byte;
                        n_len = r_len + 64'd8;
                        n_pos = r_pos + 6'd1;
                        if (r_pos == LAST_POS) begin
                            o_start = 1'b1;
                            n_state = ST_COMP;
                            n_after = i_item.is_last ? AFT_PAD : AFT_NONE;
                        end else if (i_item.is_last) begin
                            n_state = ST_PAD;
                        end
                    end else if (i_item.is_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                for (int w = 0; w < 16; w++) begin
                    for (int k = 0; k < 4; k++) begin
                        if (6'(w * 4 + k) == r_pos) begin
                            n_blk[w][k*8 +: 8] = PAD_BYTE;
                        end else if (6'(w * 4 + k) > r_pos) begin
                            n_blk[w][k*8 +: 8] = '0;
                        end
                    end
                end
                if (r_pos >= LEN_POS) begin
                    n_after = AFT_LEN;
                end else begin
                    n_blk[14] = r_len[31:0];
                    n_blk[15] = r_len[63:32];
                    n_after   = AFT_DONE;
                end
                o_start = 1'b1;
                n_state = ST_COMP;
            end
            ST_LEN: begin
                for (int w = 0; w < 14; w++) begin
                    n_blk[w] = '0;
                end
                n_blk[14] = r_len[31:0];
                n_blk[15] = r_len[63:32];
                n_after   = AFT_DONE;
                o_start   = 1'b1;
                n_state   = ST_COMP;
            end
            ST_COMP: begin
                if (i_done) begin
                    n_chain = i_sum;
                    case (r_after)
                        AFT_NONE: n_state = ST_IDLE;
                        AFT_PAD:  n_state = ST_PAD;
                        AFT_LEN:  n_state = ST_LEN;
                        AFT_DONE: n_state = ST_OUT;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov    = 1'b1;
                    n_d1    = {swap32(r_chain[0]), swap32(r_chain[1])};
                    n_d2    = {swap32(r_chain[2]), swap32(r_chain[3])};
                    n_chain = CHAIN_INIT;
                    n_pos   = '0;
                    n_len   = '0;
                    n_after = AFT_NONE;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_after <= AFT_NONE;
            r_pos   <= '0;
            r_len   <= '0;
            r_chain <= CHAIN_INIT;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_chain <= n_chain;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_d1  <= n_d1;
        r_d2  <= n_d2;
    end

    assign o_valid              = r_ov;
    assign o_digest_first_half  = r_d1;
    assign o_digest_second_half = r_d2;
    assign o_chain              = r_chain;
    assign o_wdata              = r_blk[i_widx];

endmodule

/* hdl/md5_message_digest.sv */
// MD5 hasher that takes the message one byte per input word.
// Input channel: i_valid/o_ready with i_msg_byte, i_has_byte and i_is_last.
// A word with i_has_byte set adds i_msg_byte to the message. A word with
// i_is_last set ends the message after its byte, if any, and a word with
// neither flag is taken and ignored.
// Output channel: o_valid/i_ready with the 128-bit digest in standard byte
// order, bytes 0 to 7 on o_digest_first_half and 8 to 15 on
// o_digest_second_half, the first byte in the top bits of each.
// The 64th byte of a block starts the round unit, which hashes the block as a
// load, 64 rounds and a chain add; no byte leaves the queue while it runs.
// This single round unit sets the sustained byte rate.
// The final word adds one or two padded blocks before the digest appears;
// a two-word queue in front lets the sender run ahead by two words during
// a block.
// Reset empties the queue, clears the byte count and the length, and loads the initial chaining words.
// If the receiver stalls, the digest is held in the output register and the
// block keeps hashing the next message until a second digest is ready.
module md5_message_digest
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_digest_first_half,
    output logic [63:0] o_digest_second_half
);

    logic       item_valid;
    t_item      item;
    logic       pop;
    logic       start;
    t_chain     chain;
    logic [3:0] widx;
    t_word      wdata;
    logic       done;
    t_chain     sum;

    md5_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_msg_byte   (i_msg_byte),
        .i_has_byte   (i_has_byte),
        .i_is_last    (i_is_last),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_pop        (pop)
    );

    md5_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_item_valid         (item_valid),
        .i_item               (item),
        .o_pop                (pop),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_digest_first_half  (o_digest_first_half),
        .o_digest_second_half (o_digest_second_half),
        .o_start              (start),
        .o_chain              (chain),
        .i_widx               (widx),
        .o_wdata              (wdata),
        .i_done               (done),
        .i_sum                (sum)
    );

    md5_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_chain (chain),
        .o_widx  (widx),
        .i_wdata (wdata),
        .o_done  (done),
        .o_sum   (sum)
    );

endmodule

/* hdl/md5_checker.sv */
module md5_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        i_is_last,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_digest_first_half,
    input logic [63:0] o_digest_second_half
);

    logic [2:0] r_pend;
    logic [2:0] n_pend;
    logic       last_in;
    logic       word_out;

    // Count of ended messages whose digest has not been taken yet.
    assign last_in  = i_valid && o_ready && i_is_last;
    assign word_out = o_valid && i_ready;

    always_comb begin
        n_pend = r_pend;
        if (last_in && !word_out) begin
            n_pend = r_pend + 3'd1;
        end else if (!last_in && word_out) begin
            n_pend = r_pend - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_digest_first_half)
                                && $stable(o_digest_second_half))
        else $error("Digest changed or dropped while stalled.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Digest offered right after reset.");

    a_digest_has_msg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pend != 3'd0)
        else $error("Digest offered without an ended message.");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd4)
        else $error("More ended messages held than the block can store.");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_valid              (i_valid),
    .o_ready              (o_ready),
    .i_is_last            (i_is_last),
    .o_valid              (o_valid),
    .i_ready              (i_ready),
    .o_digest_first_half  (o_digest_first_half),
    .o_digest_second_half (o_digest_second_half)
);

/* tb/sv/md5_message_digest_test.sv */
module md5_message_digest_test;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 200;
    localparam int HOLD_CYCLES = 800;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROUND_SHIFT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    typedef struct {
        logic [63:0] first_half;
        logic [63:0] second_half;
    } md5_digest_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_msg_byte;
    logic        i_has_byte;
    logic        i_is_last;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_digest_first_half;
    logic [63:0] o_digest_second_half;

    logic [31:0] hash_state [4];
    logic [31:0] msg_block [16];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;

    md5_digest_t expected_digests [$];

    int sender_idle_pct;
    int receiver_stall_pct;
    int ready_hold_cycles;
    int error_count;
    int digests_checked;
    int messages_sent;
    int bytes_sent;
    int idle_words_sent;

    md5_message_digest u_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_msg_byte           (i_msg_byte),
        .i_has_byte           (i_has_byte),
        .i_is_last            (i_is_last),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_digest_first_half  (o_digest_first_half),
        .o_digest_second_half (o_digest_second_half)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] rotate_left(input logic [31:0] x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic logic [31:0] byte_reverse(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic void restart_hash();
        hash_state[0] = 32'h67452301;
        hash_state[1] = 32'hefcdab89;
        hash_state[2] = 32'h98badcfe;
        hash_state[3] = 32'h10325476;
        foreach (msg_block[w]) msg_block[w] = 32'h0;
        fill_pos = 6'd0;
        msg_bits = 64'd0;
    endfunction

    function automatic void store_block_byte(input int pos, input logic [7:0] v);
        msg_block[pos / 4][(pos % 4) * 8 +: 8] = v;
    endfunction

    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t, nb;
        int k;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    k = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    k = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    k = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    k = (7 * i) % 16;
                end
            endcase
            t = a + f + msg_block[k] + ROUND_CONST[i];
            nb = b + rotate_left(t, ROUND_SHIFT[(i / 16) * 4 + i % 4]);
            a = d;
            d = c;
            c = b;
            b = nb;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
    endfunction

    function automatic void predict_word(input logic [7:0] b, input logic has,
                                         input logic last);
        md5_digest_t dg;
        int p;
        if (has) begin
            store_block_byte(int'(fill_pos), b);
            msg_bits = msg_bits + 64'd8;
            fill_pos = fill_pos + 6'd1;
            if (fill_pos == 6'd0) begin
                compress_block();
            end
        end
        if (last) begin
            store_block_byte(int'(fill_pos), 8'h80);
            p = int'(fill_pos) + 1;
            if (p > 56) begin
                while (p < 64) begin
                    store_block_byte(p, 8'h00);
                    p++;
                end
                compress_block();
                p = 0;
            end
            while (p < 56) begin
                store_block_byte(p, 8'h00);
                p++;
            end
            msg_block[14] = msg_bits[31:0];
            msg_block[15] = msg_bits[63:32];
            compress_block();
            dg.first_half = {byte_reverse(hash_state[0]), byte_reverse(hash_state[1])};
            dg.second_half = {byte_reverse(hash_state[2]), byte_reverse(hash_state[3])};
            expected_digests.push_back(dg);
            restart_hash();
        end
    endfunction

    task automatic send_word(input logic [7:0] b, input logic has, input logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_msg_byte = b;
        i_has_byte = has;
        i_is_last = last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_word(b, has, last);
        if (has) bytes_sent++;
        if (!has && !last) idle_words_sent++;
        if (last) messages_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit end_on_byte, input int noise_pct);
        logic ends_here;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < noise_pct) begin
                send_word(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            ends_here = end_on_byte && (i == len - 1);
            send_word(8'($urandom_range(255)), 1'b1, ends_here);
        end
        if (!end_on_byte || len == 0) begin
            send_word(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_for_digests();
        i_valid = 1'b0;
        while (expected_digests.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_empty_message();
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hff, 1'b0, 1'b1);
    endtask

    task automatic test_idle_words_and_last_byte();
        send_word(8'h5a, 1'b0, 1'b0);
        send_word("a", 1'b1, 1'b0);
        send_word(8'ha5, 1'b0, 1'b0);
        send_word("b", 1'b1, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_word("c", 1'b1, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hff, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
        send_word(8'hff, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h55, 1'b1, 1'b0);
        send_word(8'haa, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_block_boundaries();
        int lengths [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
        foreach (lengths[n]) begin
            send_message(lengths[n], (n % 2) == 1, 0);
            send_message(lengths[n], (n % 2) == 0, 3);
        end
    endtask

    task automatic test_full_rate();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        for (int m = 0; m < 6; m++) begin
            send_message($urandom_range(1, 100), 1'($urandom_range(1)), 0);
        end
        sender_idle_pct = 21;
        receiver_stall_pct = 21;
    endtask

    task automatic test_output_backpressure();
        wait_for_digests();
        ready_hold_cycles = HOLD_CYCLES;
        for (int m = 0; m < 8; m++) begin
            send_message($urandom_range(0, 6), 1'($urandom_range(1)), 0);
        end
        wait_for_digests();
    endtask

    task automatic test_random_messages();
        int len;
        int pick;
        int start_count;
        start_count = bytes_sent + messages_sent;
        while (bytes_sent + messages_sent - start_count < 400) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(0, 20);
            end else if (pick < 92) begin
                len = $urandom_range(21, 130);
            end else begin
                len = $urandom_range(131, 300);
            end
            send_message(len, 1'($urandom_range(1)), 5);
            if ($urandom_range(99) < 10) begin
                wait_for_digests();
            end
        end
    endtask

    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (ready_hold_cycles > 0) begin
                i_ready = 1'b0;
                ready_hold_cycles--;
            end else begin
                i_ready = ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial begin
        md5_digest_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
                if (expected_digests.size() == 0) begin
                    $display("%0t: unexpected digest %h %h", $time,
                             o_digest_first_half, o_digest_second_half);
                    error_count++;
                end else begin
                    want = expected_digests.pop_front();
                    digests_checked++;
                    if (o_digest_first_half !== want.first_half) begin
                        $display("%0t: digest first half expected %h actual %h", $time,
                                 want.first_half, o_digest_first_half);
                        error_count++;
                    end
                    if (o_digest_second_half !== want.second_half) begin
                        $display("%0t: digest second half expected %h actual %h", $time,
                                 want.second_half, o_digest_second_half);
                        error_count++;
                    end
                end
            end
        end
    end

    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        @(posedge i_rst_n);
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
        $display("md5_message_digest regression: fail");
        $finish;
    end

    initial begin
        sender_idle_pct = 21;
        receiver_stall_pct = 21;
        ready_hold_cycles = 0;
        error_count = 0;
        digests_checked = 0;
        messages_sent = 0;
        bytes_sent = 0;
        idle_words_sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_msg_byte = 8'h00;
        i_has_byte = 1'b0;
        i_is_last = 1'b0;
        restart_hash();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_message();
        test_idle_words_and_last_byte();
        test_byte_extremes();
        test_block_boundaries();
        test_full_rate();
        test_output_backpressure();
        test_random_messages();

        wait_for_digests();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (expected_digests.size() != 0) begin
            error_count++;
        end
        $display("Hashed %0d messages of %0d bytes with %0d ignored words; %0d digests checked.",
                 messages_sent, bytes_sent, idle_words_sent, digests_checked);
        $display("Covered empty messages, block-boundary lengths, full rate and back-pressure.");
        if (error_count == 0) begin
            $display("md5_message_digest regression: pass");
        end else begin
            $display("md5_message_digest regression: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/md5_pkg.sv
hdl/md5_front.sv
hdl/md5_round.sv
hdl/md5_back.sv
hdl/md5_message_digest.sv
hdl/md5_checker.sv
tb/sv/md5_message_digest_test.sv
